### src/fxalu_pkg.sv
package fxalu_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_GE       = 4'd5,
    OP_LT       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_t;

  localparam int WORD_W = 32;

  // One input transfer.
  typedef struct packed {
    op_t                operation;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } alu_in_t;

  // One result transfer.
  typedef struct packed {
    logic signed [31:0] result_word;
    logic               compare_true;
    logic               divide_by_zero;
  } alu_out_t;

  // Sideband that follows an item down the pipeline.
  typedef struct packed {
    logic               valid;
    op_t                operation;
    logic               neg;
    logic               div_zero;
    logic signed [31:0] simple_word;
    logic               compare_true;
  } fxalu_tag_t;

endpackage

### src/fxalu_mul.sv
// Pipelined magnitude multiplier: four 16x16 partial products, then a sum,
// then rounding and a delay; the caller sets Stages to match the divider.
module fxalu_mul #(
  parameter int FracBits = 8,
  parameter int Stages   = 34
) (
  input  logic        clk,
  input  logic [31:0] mag_a,
  input  logic [31:0] mag_b,
  output logic [63:0] product
);

  logic [31:0] pp_ll, pp_lh, pp_hl, pp_hh;
  logic [63:0] sum;
  logic [63:0] rounded;
  logic [63:0] delay [Stages-3];

  // Partial products.
  always_ff @(posedge clk) begin
    pp_ll <= mag_a[15:0]  * mag_b[15:0];
    pp_lh <= mag_a[15:0]  * mag_b[31:16];
    pp_hl <= mag_a[31:16] * mag_b[15:0];
    pp_hh <= mag_a[31:16] * mag_b[31:16];
  end

  // Sum of partial products.
  always_ff @(posedge clk) begin
    sum <= {pp_hh, pp_ll} + ({32'd0, pp_lh} << 16) + ({32'd0, pp_hl} << 16);
  end

  // Round half away from zero on the magnitude.
  always_ff @(posedge clk) begin
    rounded <= (sum + (64'd1 << (FracBits - 1))) >> FracBits;
  end

  // Delay to line up with the divider.
  always_ff @(posedge clk) begin
    delay[0] <= rounded;
    for (int i = 1; i < Stages - 3; i++) begin
      delay[i] <= delay[i-1];
    end
  end

  assign product = delay[Stages-4];

endmodule

### src/fxalu_div.sv
// Pipelined restoring divider, one quotient bit per stage, plus a rounding
// step on the final remainder. Quotient has 32+FracBits bits.
module fxalu_div #(
  parameter int FracBits = 8
) (
  input  logic        clk,
  input  logic [31:0] mag_a,
  input  logic [31:0] mag_b,
  output logic [63:0] quotient
);

  localparam int QW = 32 + FracBits;

  logic [QW-1:0] num [QW+1];
  logic [QW-1:0] quo [QW+1];
  logic [32:0]   rem [QW+1];
  logic [31:0]   den [QW+1];

  assign num[0] = {mag_a, FracBits'(0)};
  assign quo[0] = '0;
  assign rem[0] = '0;
  assign den[0] = mag_b;

  // One quotient bit per stage, MSB first.
  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [33:0] trial;
    logic [33:0] diff;
    assign trial = {rem[s][32:0], num[s][QW-1]};
    assign diff  = trial - {2'b0, den[s]};
    always_ff @(posedge clk) begin
      num[s+1] <= num[s] << 1;
      den[s+1] <= den[s];
      if (!diff[33]) begin
        rem[s+1] <= diff[32:0];
        quo[s+1] <= {quo[s][QW-2:0], 1'b1};
      end else begin
        rem[s+1] <= trial[32:0];
        quo[s+1] <= {quo[s][QW-2:0], 1'b0};
      end
    end
  end

  // Round half away from zero: bump when twice the remainder reaches divisor.
  always_ff @(posedge clk) begin
    if ({rem[QW], 1'b0} >= {2'b0, den[QW]}) begin
      quotient <= 64'(quo[QW]) + 64'd1;
    end else begin
      quotient <= 64'(quo[QW]);
    end
  end

endmodule

### src/fixed_point_alu.sv
// The pipeline depth is set by the divider (one quotient bit per stage plus
//   rounding); the multiplier is delayed to match it.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// Results appear for one cycle with strobe; the receiver cannot stall.
// Reset (rst, synchronous, active high) clears all valid bits.
// Operations other than mul/div travel the same pipe for in-order results.
module fixed_point_alu #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  fxalu_pkg::alu_in_t   operands,
  output logic                 strobe,
  output fxalu_pkg::alu_out_t  result
);

  localparam int DivLat = 32 + FRACTION_BITS + 1;
  localparam int Lat    = DivLat + 2;

  fxalu_pkg::fxalu_tag_t tag_in;
  fxalu_pkg::fxalu_tag_t tags [Lat];
  logic [31:0] mag_a, mag_b, mag_a_r, mag_b_r;
  logic [63:0] product, quotient;
  logic [31:0] ua, ub;
  logic [63:0] sel;
  logic signed [31:0] sat;
  fxalu_pkg::fxalu_tag_t t_end;

  assign busy = 1'b0;
  assign ua = operands.operand_a;
  assign ub = operands.operand_b;
  assign mag_a = operands.operand_a[31] ? 32'(-ua) : ua;
  assign mag_b = operands.operand_b[31] ? 32'(-ub) : ub;

  // Decode the simple operations at entry.
  always_comb begin
    tag_in = '0;
    tag_in.valid     = start;
    tag_in.operation = operands.operation;
    tag_in.neg       = operands.operand_a[31] ^ operands.operand_b[31];
    tag_in.div_zero  = (operands.operation == fxalu_pkg::OP_DIV) && (ub == 32'd0);
    unique case (operands.operation)
      fxalu_pkg::OP_ADD:      tag_in.simple_word = operands.operand_a + operands.operand_b;
      fxalu_pkg::OP_SUB:      tag_in.simple_word = operands.operand_a - operands.operand_b;
      fxalu_pkg::OP_GT:       tag_in.compare_true = operands.operand_a > operands.operand_b;
      fxalu_pkg::OP_GE:       tag_in.compare_true = operands.operand_a >= operands.operand_b;
      fxalu_pkg::OP_LT:       tag_in.compare_true = operands.operand_a < operands.operand_b;
      fxalu_pkg::OP_LE:       tag_in.compare_true = operands.operand_a <= operands.operand_b;
      fxalu_pkg::OP_EQ:       tag_in.compare_true = operands.operand_a == operands.operand_b;
      fxalu_pkg::OP_NE:       tag_in.compare_true = operands.operand_a != operands.operand_b;
      fxalu_pkg::OP_MIN:      tag_in.simple_word = (operands.operand_a < operands.operand_b) ?
                                operands.operand_a : operands.operand_b;
      fxalu_pkg::OP_MAX:      tag_in.simple_word = (operands.operand_a > operands.operand_b) ?
                                operands.operand_a : operands.operand_b;
      fxalu_pkg::OP_INC:      tag_in.simple_word = operands.operand_a + 32'sd1;
      fxalu_pkg::OP_DEC:      tag_in.simple_word = operands.operand_a - 32'sd1;
      fxalu_pkg::OP_FROM_INT: tag_in.simple_word = operands.operand_a <<< FRACTION_BITS;
      fxalu_pkg::OP_TO_INT:   tag_in.simple_word = operands.operand_a >>> FRACTION_BITS;
      default:                tag_in.simple_word = '0;
    endcase
  end

  // Register the operand magnitudes.
  always_ff @(posedge clk) begin
    mag_a_r <= mag_a;
    mag_b_r <= mag_b;
  end

  fxalu_mul #(.FracBits(FRACTION_BITS), .Stages(DivLat)) u_mul (
    .clk(clk), .mag_a(mag_a_r), .mag_b(mag_b_r), .product(product)
  );

  fxalu_div #(.FracBits(FRACTION_BITS)) u_div (
    .clk(clk), .mag_a(mag_a_r), .mag_b(mag_b_r), .quotient(quotient)
  );

  // Tag pipeline with valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Lat; i++) tags[i].valid <= 1'b0;
    end else begin
      tags[0].valid <= tag_in.valid;
      for (int i = 1; i < Lat; i++) tags[i].valid <= tags[i-1].valid;
    end
    tags[0].operation    <= tag_in.operation;
    tags[0].neg          <= tag_in.neg;
    tags[0].div_zero     <= tag_in.div_zero;
    tags[0].simple_word  <= tag_in.simple_word;
    tags[0].compare_true <= tag_in.compare_true;
    for (int i = 1; i < Lat; i++) begin
      tags[i].operation    <= tags[i-1].operation;
      tags[i].neg          <= tags[i-1].neg;
      tags[i].div_zero     <= tags[i-1].div_zero;
      tags[i].simple_word  <= tags[i-1].simple_word;
      tags[i].compare_true <= tags[i-1].compare_true;
    end
  end

  // Saturate the selected magnitude and apply the sign.
  assign t_end = tags[Lat-2];
  assign sel = (t_end.operation == fxalu_pkg::OP_MUL) ? product : quotient;
  always_comb begin
    if (t_end.neg) begin
      sat = (sel >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(-sel[31:0]);
    end else begin
      sat = (sel > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(sel[31:0]);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= t_end.valid;
    end
    result.compare_true   <= t_end.compare_true;
    result.divide_by_zero <= t_end.div_zero;
    if (t_end.operation == fxalu_pkg::OP_MUL) begin
      result.result_word <= sat;
    end else if (t_end.operation == fxalu_pkg::OP_DIV) begin
      result.result_word <= t_end.div_zero ? 32'sd0 : sat;
    end else begin
      result.result_word <= t_end.simple_word;
    end
  end

  // A divide-by-zero flag only comes with a zero result.
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && result.divide_by_zero |-> result.result_word == 32'sd0)
    else $error("divide by zero with nonzero result");

  // A start reaches the output after the pipeline latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(Lat) strobe)
    else $error("result strobe missing");

  // Flags never both set.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !(result.compare_true && result.divide_by_zero))
    else $error("conflicting flags");

endmodule
